### hdl/cfm_pkg.sv
// cfm_pkg: shared types and constants of the ir carrier frequency meter
// used by cfm_regs, cfm_ctrl, cfm_datapath and the top level
// no dependencies
package cfm_pkg;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned DIFF_W      = 8;
  localparam int unsigned CNT_W       = IDX_W;
  localparam int unsigned SUM_W       = DIFF_W + IDX_W;
  localparam int unsigned FREQ_W      = 18;
  localparam int unsigned NUM_W       = CNT_W + FREQ_W;
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_W);
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // 1000 khz scale times 256 for 8 fraction bits
  localparam logic [FREQ_W-1:0] FREQ_SCALE = FREQ_W'(256000);
  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
  localparam logic [7:0]        COUNT_MAX  = 8'hFF;
  localparam logic [15:0]       SUM_MAX    = 16'hFFFF;

  localparam logic [DIFF_W-1:0] MIN_RESET = DIFF_W'(10);
  localparam logic [DIFF_W-1:0] MAX_RESET = DIFF_W'(50);

  // register word indexes, taken from paddr[2]
  localparam logic REG_MIN = 1'b0;
  localparam logic REG_MAX = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE    = 2'd0,
    KIND_COMPUTE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } cfm_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } cfm_state_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic start;
    logic walk;
    logic mul;
    logic div_step;
    logic load;
  } cfm_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_free;
  } cfm_sts_t;

endpackage

### hdl/ir_carrier_frequency_meter_unit.sv
// ir_carrier_frequency_meter_unit: top level of the ir carrier frequency meter
// instantiates cfm_regs, cfm_ctrl and cfm_datapath; depends on cfm_pkg
//
// usage:
//   slave stream: tuser carries the kind (edge capture, compute, clear) and
//   tdata the microsecond edge timestamp. an edge writes the stamp into a
//   256-entry ring; a clear empties the ring and its write index at once.
//   a compute walks the ring and returns one transaction on the master
//   stream with count, sum, frequency in khz (q8) and the have-data flag.
//   apb port: min interval at 0x0, max interval at 0x4; pready is always high.
// sequence:
//   an edge or a clear is done on acceptance. an accepted compute reads
//   all 256 ring entries on the single read port, then runs one drain,
//   one multiply, the bit-serial divider and a load of the output register.
//   no input is taken during that; the next transaction can be taken in
//   the cycle after the load.
// reset and stall:
//   reset empties the ring and loads window 10..50 us. a stalled result sits
//   in the output register; edges and clears are still taken, and a further
//   compute finishes its work and waits until the register frees up.
module ir_carrier_frequency_meter_unit
  import cfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TIME_W-1:0]     s_axis_tdata,  // [31:0] timestamp
  input  logic [KIND_W-1:0]     s_axis_tuser,  // [1:0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] sample_count, [23:8] interval_sum, [41:24] freq_khz_q8,
  // [42] have_data, [47:43] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DIFF_W-1:0] min_int;
  logic [DIFF_W-1:0] max_int;
  cfm_cmd_t          cmd;
  cfm_sts_t          sts;

  cfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .min_o   (min_int),
    .max_o   (max_int)
  );

  cfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .timestamp_i (s_axis_tdata),
    .min_i       (min_int),
    .max_i       (max_int),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### hdl/cfm_regs.sv
// cfm_regs: apb register file holding the accepted interval window
// depends on cfm_pkg
module cfm_regs
  import cfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DIFF_W-1:0]     min_o,
  output logic [DIFF_W-1:0]     max_o
);

  logic [DIFF_W-1:0] min_q, min_d;
  logic [DIFF_W-1:0] max_q, max_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      if (paddr[2] == REG_MIN) begin
        min_d = pwdata[DIFF_W-1:0];
      end else begin
        max_d = pwdata[DIFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign prdata = (paddr[2] == REG_MIN) ? CFG_DATA_W'(min_q) : CFG_DATA_W'(max_q);
  assign min_o  = min_q;
  assign max_o  = max_q;

endmodule

### hdl/cfm_ctrl.sv
// cfm_ctrl: sequencer for capture, clear and the compute walk and divide
// depends on cfm_pkg
module cfm_ctrl
  import cfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] kind_i,
  output logic              in_ready_o,
  input  cfm_sts_t          sts_i,
  output cfm_cmd_t          cmd_o
);

  cfm_state_e state_q, state_d;
  cfm_kind_e  kind;
  logic       accept;

  assign kind   = cfm_kind_e'(kind_i);
  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (kind)
            KIND_EDGE:    cmd_o.capture = 1'b1;
            KIND_CLEAR:   cmd_o.clear   = 1'b1;
            KIND_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read entry is folded into the sums here
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/cfm_datapath.sv
// cfm_datapath: stamp ring, interval accumulators, divider and output register
// depends on cfm_pkg
module cfm_datapath
  import cfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfm_cmd_t              cmd_i,
  output cfm_sts_t              sts_o,
  input  logic [TIME_W-1:0]     timestamp_i,
  input  logic [DIFF_W-1:0]     min_i,
  input  logic [DIFF_W-1:0]     max_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  // each entry keeps the low stamp bits and a nonzero flag of the full stamp
  logic [DIFF_W:0]       mem [ENTRIES];
  logic [ENTRIES-1:0]    vld_q;
  logic [IDX_W-1:0]      wr_idx_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_vld_q;
  logic [DIFF_W:0]       ent_q;
  logic                  ent_vld_q;
  logic [DIFF_W:0]       ent;
  logic [DIFF_W-1:0]     prev_q;
  logic [DIFF_W-1:0]     diff;
  logic                  keep;
  logic [CNT_W-1:0]      cnt_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  have_q;
  logic [NUM_W-1:0]      num_q;
  logic [SUM_W-1:0]      rem_q;
  logic [SUM_W:0]        rem_sh;
  logic                  q_bit;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [7:0]            cnt_sat;
  logic [15:0]           sum_sat;
  logic [FREQ_W-1:0]     freq;

  // ring writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mem[wr_idx_q] <= {(timestamp_i != '0), timestamp_i[DIFF_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      vld_q    <= '0;
      wr_idx_q <= '0;
    end else if (cmd_i.capture) begin
      vld_q[wr_idx_q] <= 1'b1;
      wr_idx_q <= (wr_idx_q == IDX_W'(ENTRIES - 1)) ? '0 : wr_idx_q + 1'b1;
    end
  end

  // walk: address issue, registered read, then accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk;
      if (cmd_i.start) begin
        rd_addr_q <= '0;
      end else if (cmd_i.walk) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_addr_q;
    ent_vld_q <= vld_q[rd_addr_q];
  end

  assign ent  = ent_vld_q ? ent_q : '0;
  assign diff = ent[DIFF_W-1:0] - prev_q;
  assign keep = (diff >= min_i) && (diff <= max_i) && (rd_idx_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      have_q <= 1'b0;
    end else if (rd_vld_q) begin
      prev_q <= ent[DIFF_W-1:0];
      if (keep) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + SUM_W'(diff);
      end
      if (rd_idx_q >= IDX_W'(ENTRIES - 2)) begin
        have_q <= have_q | ent[DIFF_W];
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, sum_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q     <= NUM_W'(cnt_q) * NUM_W'(FREQ_SCALE);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= q_bit ? SUM_W'(rem_sh - {1'b0, sum_q}) : SUM_W'(rem_sh);
      num_q     <= {num_q[NUM_W-2:0], q_bit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign sts_o.walk_last = (rd_addr_q == IDX_W'(ENTRIES - 1));
  assign sts_o.div_last  = (div_cnt_q == DIV_CNT_W'(NUM_W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // clamp count and sum to the widths of their output fields
  assign cnt_sat = (cnt_q > CNT_W'(COUNT_MAX)) ? COUNT_MAX : 8'(cnt_q);
  assign sum_sat = (sum_q > SUM_W'(SUM_MAX)) ? SUM_MAX : 16'(sum_q);

  always_comb begin
    if (sum_q == '0) begin
      freq = '0;
    end else if (num_q > NUM_W'(FREQ_MAX)) begin
      freq = FREQ_MAX;
    end else begin
      freq = FREQ_W'(num_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= OUT_DATA_W'({have_q, freq, sum_sat, cnt_sat});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
